// ===== rtl/tpga_pkg.sv =====
package tpga_pkg;

    // Result format and multiplier digit size
    localparam int ACC_WIDTH  = 48;
    localparam int DIGIT_BITS = 8;
    localparam int PROG_LEN   = 45;
    localparam int PC_BITS    = 6;

    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    // Vertex slot codes
    localparam logic [1:0] SLOT_PATCH = 2'd0;
    localparam logic [1:0] SLOT_LAST  = 2'd3;

    typedef enum logic [1:0] {AX_X, AX_Y, AX_Z, AX_U} axis_t;
    typedef enum logic [2:0] {V_P, V_1, V_2, V_3, V_ZERO} vtx_t;

    // Narrow operand: coordinate difference p - q along one axis
    typedef struct packed {
        axis_t axis;
        vtx_t  p;
        vtx_t  q;
    } opd_t;

    typedef enum logic [2:0] {DST_C, DST_DET, DST_GX, DST_GY, DST_GZ} dst_t;
    typedef enum logic [1:0] {OP_SET, OP_ADD, OP_SUB, OP_NEG} wop_t;

    typedef struct packed {
        logic  a_is_c;
        opd_t  a;
        opd_t  b;
        dst_t  dst;
        wop_t  op;
    } instr_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_WB, ST_DLOAD, ST_DIV, ST_ACC, ST_OUT
    } state_t;

    // Edge vectors from the patch node
    localparam opd_t EX1 = '{AX_X, V_1, V_P};
    localparam opd_t EX2 = '{AX_X, V_2, V_P};
    localparam opd_t EX3 = '{AX_X, V_3, V_P};
    localparam opd_t EY1 = '{AX_Y, V_1, V_P};
    localparam opd_t EY2 = '{AX_Y, V_2, V_P};
    localparam opd_t EY3 = '{AX_Y, V_3, V_P};
    localparam opd_t EZ1 = '{AX_Z, V_1, V_P};
    localparam opd_t EZ2 = '{AX_Z, V_2, V_P};
    localparam opd_t EZ3 = '{AX_Z, V_3, V_P};
    // Differences between face vertices
    localparam opd_t X23 = '{AX_X, V_2, V_3};
    localparam opd_t X12 = '{AX_X, V_1, V_2};
    localparam opd_t X13 = '{AX_X, V_1, V_3};
    localparam opd_t Y23 = '{AX_Y, V_2, V_3};
    localparam opd_t Y12 = '{AX_Y, V_1, V_2};
    localparam opd_t Y13 = '{AX_Y, V_1, V_3};
    localparam opd_t Z23 = '{AX_Z, V_2, V_3};
    localparam opd_t Z12 = '{AX_Z, V_1, V_2};
    localparam opd_t Z13 = '{AX_Z, V_1, V_3};
    // Field values
    localparam opd_t U1  = '{AX_U, V_1, V_ZERO};
    localparam opd_t U2  = '{AX_U, V_2, V_ZERO};
    localparam opd_t U3  = '{AX_U, V_3, V_ZERO};
    localparam opd_t UP  = '{AX_U, V_P, V_ZERO};

    function automatic instr_t mk(logic a_is_c, opd_t a, opd_t b, dst_t dst, wop_t op);
        instr_t r;
        r = '{a_is_c, a, b, dst, op};
        return r;
    endfunction

    // Element program: determinant, then the three gradient numerators
    function automatic instr_t ucode(logic [PC_BITS-1:0] pc);
        instr_t r;
        r = mk(1'b0, EX1, EX1, DST_C, OP_SET);
        case (pc)
            6'd0:  r = mk(1'b0, EX2, EY3, DST_C,   OP_SET);
            6'd1:  r = mk(1'b0, EX3, EY2, DST_C,   OP_SUB);
            6'd2:  r = mk(1'b1, EX1, EZ1, DST_DET, OP_SET);
            6'd3:  r = mk(1'b0, EX2, EZ3, DST_C,   OP_SET);
            6'd4:  r = mk(1'b0, EZ2, EX3, DST_C,   OP_SUB);
            6'd5:  r = mk(1'b1, EX1, EY1, DST_DET, OP_SUB);
            6'd6:  r = mk(1'b0, EY2, EZ3, DST_C,   OP_SET);
            6'd7:  r = mk(1'b0, EZ2, EY3, DST_C,   OP_SUB);
            6'd8:  r = mk(1'b1, EX1, EX1, DST_DET, OP_ADD);
            6'd9:  r = mk(1'b0, EZ2, Y23, DST_C,   OP_SET);
            6'd10: r = mk(1'b0, Z23, EY2, DST_C,   OP_SUB);
            6'd11: r = mk(1'b1, EX1, U1,  DST_GX,  OP_SET);
            6'd12: r = mk(1'b0, Z13, EY3, DST_C,   OP_SET);
            6'd13: r = mk(1'b0, Y13, EZ3, DST_C,   OP_SUB);
            6'd14: r = mk(1'b1, EX1, U2,  DST_GX,  OP_SUB);
            6'd15: r = mk(1'b0, EZ2, EY1, DST_C,   OP_SET);
            6'd16: r = mk(1'b0, EZ1, EY2, DST_C,   OP_SUB);
            6'd17: r = mk(1'b1, EX1, U3,  DST_GX,  OP_ADD);
            6'd18: r = mk(1'b0, Y12, Z13, DST_C,   OP_SET);
            6'd19: r = mk(1'b0, Y13, Z12, DST_C,   OP_SUB);
            6'd20: r = mk(1'b1, EX1, UP,  DST_GX,  OP_ADD);
            6'd21: r = mk(1'b0, EZ2, X23, DST_C,   OP_SET);
            6'd22: r = mk(1'b0, EX2, Z23, DST_C,   OP_SUB);
            6'd23: r = mk(1'b1, EX1, U1,  DST_GY,  OP_NEG);
            6'd24: r = mk(1'b0, EX3, Z13, DST_C,   OP_SET);
            6'd25: r = mk(1'b0, X13, EZ3, DST_C,   OP_SUB);
            6'd26: r = mk(1'b1, EX1, U2,  DST_GY,  OP_ADD);
            6'd27: r = mk(1'b0, EZ2, EX1, DST_C,   OP_SET);
            6'd28: r = mk(1'b0, EZ1, EX2, DST_C,   OP_SUB);
            6'd29: r = mk(1'b1, EX1, U3,  DST_GY,  OP_SUB);
            6'd30: r = mk(1'b0, Z13, X12, DST_C,   OP_SET);
            6'd31: r = mk(1'b0, Z12, X13, DST_C,   OP_SUB);
            6'd32: r = mk(1'b1, EX1, UP,  DST_GY,  OP_SUB);
            6'd33: r = mk(1'b0, X23, EY2, DST_C,   OP_SET);
            6'd34: r = mk(1'b0, EX2, Y23, DST_C,   OP_SUB);
            6'd35: r = mk(1'b1, EX1, U1,  DST_GZ,  OP_SET);
            6'd36: r = mk(1'b0, EX3, Y13, DST_C,   OP_SET);
            6'd37: r = mk(1'b0, X13, EY3, DST_C,   OP_SUB);
            6'd38: r = mk(1'b1, EX1, U2,  DST_GZ,  OP_SUB);
            6'd39: r = mk(1'b0, EX1, EY2, DST_C,   OP_SET);
            6'd40: r = mk(1'b0, EX2, EY1, DST_C,   OP_SUB);
            6'd41: r = mk(1'b1, EX1, U3,  DST_GZ,  OP_ADD);
            6'd42: r = mk(1'b0, Y13, X12, DST_C,   OP_SET);
            6'd43: r = mk(1'b0, Y12, X13, DST_C,   OP_SUB);
            6'd44: r = mk(1'b1, EX1, UP,  DST_GZ,  OP_ADD);
            default: r = mk(1'b0, EX1, EX1, DST_C, OP_SET);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tet_patch_gradient_accumulator.sv =====
// Patch gradient accumulator for linear tetrahedra.
// Input channel (in_valid/in_ready): one vertex item per handshake. A slot 0
// item loads the patch node and clears the sums and flags; slots 1 and 2 load
// face vertices and leave in_ready high. A slot 3 item loads the last
// face vertex and starts the element computation; in_ready stays low until
// the element is done and, for a last element, its result is registered.
// The element program runs 45 multiply instructions on the single W x 9
// multiplier, W = 3*COORD_WIDTH + FRAC_BITS + 8; a one-bit-per-cycle restoring
// divider then makes the quotient for each of the three gradient axes.
// A zero determinant skips the divide passes and sets degenerate_flag.
// Output channel (out_valid/out_ready): when the slot 3 item has
// last_in_patch set, the saturated sums and flags go to an output register.
// A stalled result holds there while slot 0..2 items keep being taken; a
// following last element waits until that register frees.
// Reset clears all vertex registers, the sums, the flags and out_valid.
module tet_patch_gradient_accumulator #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           vertex_slot,
    input  logic signed [COORD_WIDTH-1:0]        coord_x,
    input  logic signed [COORD_WIDTH-1:0]        coord_y,
    input  logic signed [COORD_WIDTH-1:0]        coord_z,
    input  logic signed [COORD_WIDTH-1:0]        value_u,
    input  logic                                 last_in_patch,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tpga_pkg::ACC_WIDTH-1:0] grad_sum_x,
    output logic signed [tpga_pkg::ACC_WIDTH-1:0] grad_sum_y,
    output logic signed [tpga_pkg::ACC_WIDTH-1:0] grad_sum_z,
    output logic                                 degenerate_flag,
    output logic                                 saturated_flag
);
    import tpga_pkg::*;

    localparam int WW = 3 * COORD_WIDTH + FRAC_BITS + 8;
    localparam int NW = COORD_WIDTH + 1;
    localparam int ND = (NW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int BW = ND * DIGIT_BITS;
    localparam int DB = (ND > 1) ? $clog2(ND) : 1;
    localparam int KB = $clog2(WW);

    state_t state_reg, state_next;
    logic [PC_BITS-1:0] pc_reg, pc_next;
    logic [DB-1:0] dcnt_reg, dcnt_next;
    logic [KB-1:0] bcnt_reg, bcnt_next;
    logic [1:0] axis_reg, axis_next;
    logic last_reg, last_next;

    logic signed [COORD_WIDTH-1:0] pt_x_reg [0:3];
    logic signed [COORD_WIDTH-1:0] pt_y_reg [0:3];
    logic signed [COORD_WIDTH-1:0] pt_z_reg [0:3];
    logic signed [COORD_WIDTH-1:0] pt_u_reg [0:3];
    logic signed [COORD_WIDTH-1:0] pt_x_next [0:3];
    logic signed [COORD_WIDTH-1:0] pt_y_next [0:3];
    logic signed [COORD_WIDTH-1:0] pt_z_next [0:3];
    logic signed [COORD_WIDTH-1:0] pt_u_next [0:3];

    logic signed [WW-1:0] a_reg, a_next;
    logic [BW-1:0] b_reg, b_next;
    logic [WW-1:0] p_reg, p_next;
    logic [WW-1:0] c_reg, c_next, det_reg, det_next;
    logic [WW-1:0] gx_reg, gx_next, gy_reg, gy_next, gz_reg, gz_next;
    logic [WW-1:0] dv_reg, dv_next;
    logic [WW:0]   rem_reg, rem_next;
    logic [WW-1:0] quo_reg, quo_next;
    logic neg_reg, neg_next;

    logic [ACC_WIDTH-1:0] acc_reg [0:2];
    logic [ACC_WIDTH-1:0] acc_next [0:2];
    logic deg_reg, deg_next, sat_reg, sat_next;

    logic out_valid_reg, out_valid_next;
    logic [ACC_WIDTH-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [ACC_WIDTH-1:0] out_z_reg, out_z_next;
    logic out_deg_reg, out_deg_next, out_sat_reg, out_sat_next;

    instr_t instr;
    logic [DIGIT_BITS-1:0] digit;
    logic signed [DIGIT_BITS:0] dsig;
    logic signed [WW+DIGIT_BITS:0] prod;
    logic [WW-1:0] cur, wres, num, mag;
    logic [WW:0] trem, tdiff;
    logic ge;
    logic signed [WW:0] qs;
    logic q_ok, s_ok;
    logic [ACC_WIDTH-1:0] q48, acc_new, acc_cur;
    logic [ACC_WIDTH:0] sum;

    // Coordinate of one vertex along one axis; the zero vertex reads as 0
    function automatic logic signed [NW-1:0] coord_sel(axis_t ax, vtx_t v);
        logic signed [COORD_WIDTH-1:0] c;
        logic [1:0] idx;
        c = '0;
        idx = v[1:0];
        if (v != V_ZERO) begin
            unique case (ax)
                AX_X: c = pt_x_reg[idx];
                AX_Y: c = pt_y_reg[idx];
                AX_Z: c = pt_z_reg[idx];
                AX_U: c = pt_u_reg[idx];
                default: c = '0;
            endcase
        end
        return NW'(c);
    endfunction

    function automatic logic signed [NW-1:0] opd_value(opd_t o);
        return coord_sel(o.axis, o.p) - coord_sel(o.axis, o.q);
    endfunction

    assign instr = ucode(pc_reg);
    assign in_ready = (state_reg == ST_IDLE);

    // Multiplier digit step, top digit signed
    always_comb
    begin
        digit = b_reg[BW-1 -: DIGIT_BITS];
        dsig  = (dcnt_reg == '0) ? {digit[DIGIT_BITS-1], digit} : {1'b0, digit};
        prod  = a_reg * dsig;
    end

    // Destination read and write-back result
    always_comb
    begin
        case (instr.dst)
            DST_C:   cur = c_reg;
            DST_DET: cur = det_reg;
            DST_GX:  cur = gx_reg;
            DST_GY:  cur = gy_reg;
            default: cur = gz_reg;
        endcase
        case (instr.op)
            OP_SET:  wres = p_reg;
            OP_ADD:  wres = cur + p_reg;
            OP_SUB:  wres = cur - p_reg;
            default: wres = '0 - p_reg;
        endcase
    end

    // Numerator magnitude, divider step, clamp and accumulate
    always_comb
    begin
        case (axis_reg)
            2'd0:    num = gx_reg;
            2'd1:    num = gy_reg;
            default: num = gz_reg;
        endcase
        mag   = num[WW-1] ? ('0 - num) : num;
        trem  = {rem_reg[WW-1:0], quo_reg[WW-1]};
        tdiff = trem - {1'b0, dv_reg};
        ge    = (trem >= {1'b0, dv_reg});
        qs    = neg_reg ? ('0 - {1'b0, quo_reg}) : {1'b0, quo_reg};
        q_ok  = (qs[WW:ACC_WIDTH-1] == '0) || (qs[WW:ACC_WIDTH-1] == '1);
        q48   = q_ok ? qs[ACC_WIDTH-1:0] : (qs[WW] ? ACC_MIN : ACC_MAX);
        acc_cur = acc_reg[axis_reg];
        sum   = {acc_cur[ACC_WIDTH-1], acc_cur} + {q48[ACC_WIDTH-1], q48};
        s_ok  = (sum[ACC_WIDTH] == sum[ACC_WIDTH-1]);
        acc_new = s_ok ? sum[ACC_WIDTH-1:0] : (sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX);
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next = state_reg;
        pc_next = pc_reg;
        dcnt_next = dcnt_reg;
        bcnt_next = bcnt_reg;
        axis_next = axis_reg;
        last_next = last_reg;
        pt_x_next = pt_x_reg;
        pt_y_next = pt_y_reg;
        pt_z_next = pt_z_reg;
        pt_u_next = pt_u_reg;
        a_next = a_reg;
        b_next = b_reg;
        p_next = p_reg;
        c_next = c_reg;
        det_next = det_reg;
        gx_next = gx_reg;
        gy_next = gy_reg;
        gz_next = gz_reg;
        dv_next = dv_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        deg_next = deg_reg;
        sat_next = sat_reg;
        out_valid_next = out_valid_reg;
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        out_z_next = out_z_reg;
        out_deg_next = out_deg_reg;
        out_sat_next = out_sat_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    pt_x_next[vertex_slot] = coord_x;
                    pt_y_next[vertex_slot] = coord_y;
                    pt_z_next[vertex_slot] = coord_z;
                    pt_u_next[vertex_slot] = value_u;
                    if (vertex_slot == SLOT_PATCH) begin
                        acc_next = '{default: '0};
                        deg_next = 1'b0;
                        sat_next = 1'b0;
                    end
                    if (vertex_slot == SLOT_LAST) begin
                        last_next = last_in_patch;
                        pc_next = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                a_next = instr.a_is_c ? $signed(c_reg) : WW'(opd_value(instr.a));
                b_next = BW'(opd_value(instr.b));
                p_next = '0;
                dcnt_next = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                p_next = (p_reg << DIGIT_BITS) + prod[WW-1:0];
                b_next = b_reg << DIGIT_BITS;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DB'(ND - 1)) begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                case (instr.dst)
                    DST_C:   c_next = wres;
                    DST_DET: det_next = wres;
                    DST_GX:  gx_next = wres;
                    DST_GY:  gy_next = wres;
                    default: gz_next = wres;
                endcase
                if (pc_reg == PC_BITS'(PROG_LEN - 1)) begin
                    axis_next = '0;
                    state_next = ST_DLOAD;
                end else begin
                    pc_next = pc_reg + 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_DLOAD:
            begin
                if (det_reg == '0) begin
                    deg_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    dv_next = det_reg[WW-1] ? ('0 - det_reg) : det_reg;
                    neg_next = num[WW-1];
                    quo_next = mag << FRAC_BITS;
                    rem_next = '0;
                    bcnt_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? tdiff : trem;
                quo_next = {quo_reg[WW-2:0], ge};
                bcnt_next = bcnt_reg + 1'b1;
                if (bcnt_reg == KB'(WW - 1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_next[axis_reg] = acc_new;
                if (!q_ok || !s_ok) begin
                    sat_next = 1'b1;
                end
                if (axis_reg == 2'd2) begin
                    state_next = ST_OUT;
                end else begin
                    axis_next = axis_reg + 1'b1;
                    state_next = ST_DLOAD;
                end
            end
            ST_OUT:
            begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_x_next = acc_reg[0];
                    out_y_next = acc_reg[1];
                    out_z_next = acc_reg[2];
                    out_deg_next = deg_reg;
                    out_sat_next = sat_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            last_reg <= 1'b0;
            pt_x_reg <= '{default: '0};
            pt_y_reg <= '{default: '0};
            pt_z_reg <= '{default: '0};
            pt_u_reg <= '{default: '0};
            acc_reg <= '{default: '0};
            deg_reg <= 1'b0;
            sat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg <= pc_next;
            last_reg <= last_next;
            pt_x_reg <= pt_x_next;
            pt_y_reg <= pt_y_next;
            pt_z_reg <= pt_z_next;
            pt_u_reg <= pt_u_next;
            acc_reg <= acc_next;
            deg_reg <= deg_next;
            sat_reg <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dcnt_reg <= dcnt_next;
        bcnt_reg <= bcnt_next;
        axis_reg <= axis_next;
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
        c_reg <= c_next;
        det_reg <= det_next;
        gx_reg <= gx_next;
        gy_reg <= gy_next;
        gz_reg <= gz_next;
        dv_reg <= dv_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_z_reg <= out_z_next;
        out_deg_reg <= out_deg_next;
        out_sat_reg <= out_sat_next;
    end

    assign out_valid = out_valid_reg;
    assign grad_sum_x = out_x_reg;
    assign grad_sum_y = out_y_reg;
    assign grad_sum_z = out_z_reg;
    assign degenerate_flag = out_deg_reg;
    assign saturated_flag = out_sat_reg;

endmodule

// ===== rtl/tpga_checker.sv =====
module tpga_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [1:0]                    vertex_slot,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tpga_pkg::ACC_WIDTH-1:0] grad_sum_x,
    input logic [tpga_pkg::ACC_WIDTH-1:0] grad_sum_y,
    input logic [tpga_pkg::ACC_WIDTH-1:0] grad_sum_z,
    input logic                          degenerate_flag,
    input logic                          saturated_flag
);
    import tpga_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(grad_sum_x)
            && $stable(grad_sum_y) && $stable(grad_sum_z)
            && $stable(degenerate_flag) && $stable(saturated_flag))
        else $error("result changed while stalled");

    // Only a slot 3 item starts a busy period
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && vertex_slot == SLOT_LAST))
        else $error("busy without an element item");

    // Other slots leave in_ready high in the cycle after they are taken
    a_fast_slots: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && vertex_slot != SLOT_LAST |=> in_ready)
        else $error("busy after a non-element item");

    // A result appears only at the end of a busy period
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without element work");

endmodule

bind tet_patch_gradient_accumulator tpga_checker u_tpga_checker (.*);
